// ----- src/agcnb_pkg.sv -----
// shared types, codes and gain tables of the receiver agc and noise blanker
package agcnb_pkg;

  localparam int unsigned IDX_W  = 4;
  localparam int unsigned WORD_W = 10;
  localparam int unsigned HANG_W = 5;
  localparam int unsigned REL_W  = 4;
  localparam int unsigned BLK_W  = 2;
  localparam int unsigned ACT_W  = 3;
  localparam int unsigned CIDX_W = 2;
  localparam int unsigned CDAT_W = 4;

  localparam logic [2:0] MODE_AUTO   = 3'd0;
  localparam logic [2:0] MODE_MANUAL = 3'd1;
  localparam logic [2:0] MODE_FAST   = 3'd2;
  localparam logic [2:0] MODE_NORM   = 3'd3;
  localparam logic [2:0] MODE_SLOW   = 3'd4;

  localparam logic [CIDX_W-1:0] REG_AGC_MODE     = 2'd0;
  localparam logic [CIDX_W-1:0] REG_GAIN_CEILING = 2'd1;
  localparam logic [CIDX_W-1:0] REG_LNA_BOOST    = 2'd2;
  localparam logic [CIDX_W-1:0] REG_BLANK_LEVEL  = 2'd3;

  localparam logic [ACT_W-1:0] ACT_NONE = 3'd0;
  localparam logic [ACT_W-1:0] ACT_MUTE = 3'd1;
  localparam logic [ACT_W-1:0] ACT_FM   = 3'd2;

  localparam logic        CMD_TICK    = 1'b0;
  localparam logic        CMD_RESTART = 1'b1;

  localparam logic signed [8:0] RSSI_ATTACK  = -9'sd65;
  localparam logic signed [8:0] RSSI_RELEASE = -9'sd90;

  localparam logic [IDX_W-1:0]  ATTACK_FAST = 4'd2;
  localparam logic [IDX_W-1:0]  ATTACK_SLOW = 4'd1;
  localparam logic [HANG_W-1:0] HANG_FAST   = 5'd2;
  localparam logic [HANG_W-1:0] HANG_NORM   = 5'd10;
  localparam logic [HANG_W-1:0] HANG_SLOW   = 5'd25;
  localparam logic [REL_W-1:0]  PERIOD_FAST = 4'd1;
  localparam logic [REL_W-1:0]  PERIOD_NORM = 4'd4;
  localparam logic [REL_W-1:0]  PERIOD_SLOW = 4'd12;

  localparam logic [2:0] LNA_MAX = 3'd7;
  localparam logic [BLK_W-1:0] BLANK_TICKS = 2'd2;

  typedef struct packed {
    logic              cmd;
    logic              rx_select;
    logic              rx_active;
    logic              audio_live;
    logic [1:0]        modulation_class;
    logic signed [8:0] rssi_dbm;
    logic [7:0]        glitch_level;
  } in_item_t;

  typedef struct packed {
    logic              gain_write;
    logic [WORD_W-1:0] gain_word;
    logic [IDX_W-1:0]  gain_index;
    logic [ACT_W-1:0]  audio_action;
  } out_item_t;

  typedef struct packed {
    logic [2:0]       agc_mode;
    logic [IDX_W-1:0] gain_ceiling;
    logic             lna_boost;
    logic [BLK_W-1:0] blank_level;
  } cfg_t;

  function automatic logic [WORD_W-1:0] gain_table(input logic [IDX_W-1:0] idx);
    logic [WORD_W-1:0] w;
    case (idx)
      4'd0:    w = 10'h000;
      4'd1:    w = 10'h011;
      4'd2:    w = 10'h003;
      4'd3:    w = 10'h00C;
      4'd4:    w = 10'h01C;
      4'd5:    w = 10'h01E;
      4'd6:    w = 10'h03E;
      4'd7:    w = 10'h05E;
      4'd8:    w = 10'h07E;
      4'd9:    w = 10'h09F;
      4'd10:   w = 10'h0FF;
      4'd11:   w = 10'h1FF;
      4'd12:   w = 10'h2FF;
      4'd13:   w = 10'h35F;
      4'd14:   w = 10'h37F;
      default: w = 10'h3FF;
    endcase
    return w;
  endfunction

  function automatic logic [WORD_W-1:0] boosted_word(input logic [IDX_W-1:0] idx,
                                                     input logic boost);
    logic [WORD_W-1:0] w;
    logic [2:0]        lna;
    w   = gain_table(idx);
    lna = w[7:5];
    if (boost && lna != LNA_MAX) begin
      w[7:5] = lna + 3'd1;
    end
    return w;
  endfunction

  function automatic logic [7:0] glitch_thr(input logic [BLK_W-1:0] level);
    logic [7:0] t;
    case (level)
      2'd1:    t = 8'd180;
      2'd2:    t = 8'd140;
      2'd3:    t = 8'd100;
      default: t = 8'd255;
    endcase
    return t;
  endfunction

endpackage

// ----- src/agcnb_if.sv -----
// valid/ready channel interfaces for items, results and register writes
interface agcnb_in_if;
  logic              valid;
  logic              ready;
  logic              cmd;
  logic              rx_select;
  logic              rx_active;
  logic              audio_live;
  logic [1:0]        modulation_class;
  logic signed [8:0] rssi_dbm;
  logic [7:0]        glitch_level;

  modport source (output valid, cmd, rx_select, rx_active, audio_live, modulation_class,
                  rssi_dbm, glitch_level, input ready);
  modport sink (input valid, cmd, rx_select, rx_active, audio_live, modulation_class,
                rssi_dbm, glitch_level, output ready);
endinterface

interface agcnb_out_if;
  import agcnb_pkg::*;
  logic              valid;
  logic              ready;
  logic              gain_write;
  logic [WORD_W-1:0] gain_word;
  logic [IDX_W-1:0]  gain_index;
  logic [ACT_W-1:0]  audio_action;

  modport source (output valid, gain_write, gain_word, gain_index, audio_action,
                  input ready);
  modport sink (input valid, gain_write, gain_word, gain_index, audio_action,
                output ready);
endinterface

interface agcnb_cfg_if;
  import agcnb_pkg::*;
  logic              valid;
  logic              ready;
  logic [CIDX_W-1:0] index;
  logic [CDAT_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- src/receiver_agc_noise_blanker_top.sv -----
// top level: item register, agc and blanker step, result register
// path: an accepted item waits in the item register until the result register is free
// throughput: one item per cycle while out_chan is ready; set by the state update of the
// selected receiver between the item register and the result register
// reset: rst_n synchronous active low; index 15, counters 0, registers to defaults
module receiver_agc_noise_blanker_top (
  input  logic        clk,
  input  logic        rst_n,
  agcnb_in_if.sink    in_chan,
  agcnb_out_if.source out_chan,
  agcnb_cfg_if.sink   cfg_chan
);
  import agcnb_pkg::*;

  cfg_t      cfg_r;
  in_item_t  item_r;
  logic      item_valid_r;
  out_item_t res_r;
  logic      res_valid_r;
  logic      step_en;
  out_item_t res_nxt;

  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.agc_mode     <= MODE_AUTO;
      cfg_r.gain_ceiling <= 4'd15;
      cfg_r.lna_boost    <= 1'b0;
      cfg_r.blank_level  <= '0;
    end else if (cfg_chan.valid) begin
      case (cfg_chan.index)
        REG_AGC_MODE:     cfg_r.agc_mode     <= cfg_chan.data[2:0];
        REG_GAIN_CEILING: cfg_r.gain_ceiling <= cfg_chan.data;
        REG_LNA_BOOST:    cfg_r.lna_boost    <= cfg_chan.data[0];
        REG_BLANK_LEVEL:  cfg_r.blank_level  <= cfg_chan.data[1:0];
        default: begin
        end
      endcase
    end
  end

  assign step_en       = item_valid_r && (!res_valid_r || out_chan.ready);
  assign in_chan.ready = !item_valid_r || step_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
      res_valid_r  <= 1'b0;
    end else begin
      if (in_chan.ready) begin
        item_valid_r <= in_chan.valid;
      end
      if (step_en) begin
        res_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        res_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      item_r.cmd              <= in_chan.cmd;
      item_r.rx_select        <= in_chan.rx_select;
      item_r.rx_active        <= in_chan.rx_active;
      item_r.audio_live       <= in_chan.audio_live;
      item_r.modulation_class <= in_chan.modulation_class;
      item_r.rssi_dbm         <= in_chan.rssi_dbm;
      item_r.glitch_level     <= in_chan.glitch_level;
    end
    if (step_en) begin
      res_r <= res_nxt;
    end
  end

  agcnb_agc u_agc (
    .clk        (clk),
    .rst_n      (rst_n),
    .step_en    (step_en),
    .item       (item_r),
    .cfg        (cfg_r),
    .gain_write (res_nxt.gain_write),
    .gain_word  (res_nxt.gain_word),
    .gain_index (res_nxt.gain_index)
  );

  agcnb_blanker u_blanker (
    .clk          (clk),
    .rst_n        (rst_n),
    .step_en      (step_en),
    .item         (item_r),
    .cfg          (cfg_r),
    .audio_action (res_nxt.audio_action)
  );

  assign out_chan.valid        = res_valid_r;
  assign out_chan.gain_write   = res_r.gain_write;
  assign out_chan.gain_word    = res_r.gain_word;
  assign out_chan.gain_index   = res_r.gain_index;
  assign out_chan.audio_action = res_r.audio_action;

endmodule

// ----- src/agcnb_blanker.sv -----
// noise blanker: mute on glitch, restore after two ticks
module agcnb_blanker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          step_en,
  input  agcnb_pkg::in_item_t           item,
  input  agcnb_pkg::cfg_t               cfg,
  output logic [agcnb_pkg::ACT_W-1:0]   audio_action
);
  import agcnb_pkg::*;

  logic [BLK_W-1:0] blank_left_r, blank_left_nxt;

  always_comb begin
    blank_left_nxt = blank_left_r;
    audio_action   = ACT_NONE;
    if (item.cmd == CMD_TICK && item.rx_active) begin
      if (blank_left_r != '0) begin
        blank_left_nxt = blank_left_r - 2'd1;
        if (blank_left_r == 2'd1 && item.audio_live) begin
          audio_action = ACT_FM + {1'b0, item.modulation_class};
        end
      end else if (cfg.blank_level != '0 && item.audio_live &&
                   item.glitch_level >= glitch_thr(cfg.blank_level)) begin
        audio_action   = ACT_MUTE;
        blank_left_nxt = BLANK_TICKS;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blank_left_r <= '0;
    end else if (step_en) begin
      blank_left_r <= blank_left_nxt;
    end
  end

endmodule

// ----- src/agcnb_agc.sv -----
// software agc of two receivers: attack, hang and release of the gain index
module agcnb_agc (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           step_en,
  input  agcnb_pkg::in_item_t            item,
  input  agcnb_pkg::cfg_t                cfg,
  output logic                           gain_write,
  output logic [agcnb_pkg::WORD_W-1:0]   gain_word,
  output logic [agcnb_pkg::IDX_W-1:0]    gain_index
);
  import agcnb_pkg::*;

  logic [IDX_W-1:0]  agc_index_r [2];
  logic              phase_r     [2];
  logic [HANG_W-1:0] hang_left_r [2];
  logic [REL_W-1:0]  rel_cnt_r   [2];

  logic [IDX_W-1:0]  idx_nxt, idx_clamp;
  logic              phase_nxt;
  logic [HANG_W-1:0] hang_nxt;
  logic [REL_W-1:0]  rel_nxt, rel_inc;
  logic              soft_mode;
  logic [IDX_W-1:0]  attack;
  logic [HANG_W-1:0] hang_set;
  logic [REL_W-1:0]  period;
  logic              sel;

  assign sel       = item.rx_select;
  assign soft_mode = (cfg.agc_mode == MODE_FAST) || (cfg.agc_mode == MODE_NORM) ||
                     (cfg.agc_mode == MODE_SLOW);
  assign idx_clamp = (agc_index_r[sel] > cfg.gain_ceiling) ? cfg.gain_ceiling
                                                            : agc_index_r[sel];
  assign rel_inc   = rel_cnt_r[sel] + 4'd1;

  always_comb begin
    case (cfg.agc_mode)
      MODE_FAST: begin
        attack = ATTACK_FAST; hang_set = HANG_FAST; period = PERIOD_FAST;
      end
      MODE_SLOW: begin
        attack = ATTACK_SLOW; hang_set = HANG_SLOW; period = PERIOD_SLOW;
      end
      default: begin
        attack = ATTACK_SLOW; hang_set = HANG_NORM; period = PERIOD_NORM;
      end
    endcase
  end

  always_comb begin
    idx_nxt    = agc_index_r[sel];
    phase_nxt  = phase_r[sel];
    hang_nxt   = hang_left_r[sel];
    rel_nxt    = rel_cnt_r[sel];
    gain_write = 1'b0;
    if (item.cmd == CMD_RESTART) begin
      idx_nxt    = cfg.gain_ceiling;
      phase_nxt  = 1'b0;
      hang_nxt   = '0;
      rel_nxt    = '0;
      gain_write = (cfg.agc_mode != MODE_AUTO);
    end else if (item.rx_active && soft_mode) begin
      idx_nxt    = idx_clamp;
      gain_write = (agc_index_r[sel] > cfg.gain_ceiling);
      if (!phase_r[sel]) begin
        phase_nxt = 1'b1;
      end else begin
        phase_nxt = 1'b0;
        if (item.rssi_dbm > RSSI_ATTACK) begin
          idx_nxt  = (idx_clamp > attack) ? idx_clamp - attack : '0;
          hang_nxt = hang_set;
          rel_nxt  = '0;
        end else if (hang_left_r[sel] != '0) begin
          hang_nxt = hang_left_r[sel] - 5'd1;
          rel_nxt  = '0;
        end else if (item.rssi_dbm < RSSI_RELEASE && idx_clamp < cfg.gain_ceiling) begin
          rel_nxt = rel_inc;
          if (rel_inc >= period) begin
            rel_nxt = '0;
            idx_nxt = idx_clamp + 4'd1;
          end
        end else begin
          rel_nxt = '0;
        end
        if (idx_nxt != idx_clamp) begin
          gain_write = 1'b1;
        end
      end
    end
  end

  assign gain_index = idx_nxt;
  assign gain_word  = gain_write ? boosted_word(idx_nxt, cfg.lna_boost) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < 2; r++) begin
        agc_index_r[r] <= 4'd15;
        phase_r[r]     <= 1'b0;
        hang_left_r[r] <= '0;
        rel_cnt_r[r]   <= '0;
      end
    end else if (step_en) begin
      agc_index_r[sel] <= idx_nxt;
      phase_r[sel]     <= phase_nxt;
      hang_left_r[sel] <= hang_nxt;
      rel_cnt_r[sel]   <= rel_nxt;
    end
  end

endmodule
